### design/mgsqr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the MGS QR unit.
// No dependencies.
package mgsqr_pkg;

   localparam int MAX_ROWS = 16;
   localparam int MAX_COLS = 16;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 5;
   localparam int ADDR_W   = 8;
   localparam int DATA_W   = 32;
   localparam int DEPTH    = 256;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_START  = 2'd1,
      ACT_READ_Q = 2'd2,
      ACT_READ_R = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_NORM = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              q_we;
      logic [ADDR_W-1:0] q_waddr;
      logic [DATA_W-1:0] q_wdata;
      logic              r_we;
      logic [ADDR_W-1:0] r_waddr;
      logic [DATA_W-1:0] r_wdata;
   } mem_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero_norm;
      logic saturated;
   } eng_status_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] val;
   } sat32_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] val;
   } sat64_type;

   // Q32.32 to Q16.16, round to nearest, ties up
   function automatic logic signed [63:0] round16(input logic signed [63:0] x);
      logic signed [48:0] r;
      r = $signed({x[63], x[63:16]}) + $signed({48'd0, x[15]});
      return 64'(r);
   endfunction

   function automatic sat32_type sat32(input logic signed [63:0] v);
      sat32_type s;
      if (v > 64'sh000000007FFFFFFF) begin
         s.hit = 1'b1;
         s.val = 32'h7FFFFFFF;
      end else if (v < 64'shFFFFFFFF80000000) begin
         s.hit = 1'b1;
         s.val = 32'h80000000;
      end else begin
         s.hit = 1'b0;
         s.val = v[31:0];
      end
      return s;
   endfunction

   function automatic sat64_type sat_add64(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      sat64_type   s;
      logic [63:0] sum;
      sum = a + b;
      if (!a[63] && !b[63] && sum[63]) begin
         s.hit = 1'b1;
         s.val = 64'h7FFFFFFFFFFFFFFF;
      end else if (a[63] && b[63] && !sum[63]) begin
         s.hit = 1'b1;
         s.val = 64'h8000000000000000;
      end else begin
         s.hit = 1'b0;
         s.val = sum;
      end
      return s;
   endfunction

endpackage

### design/mgsqr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mgsqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### design/mgsqr_sqrt.sv
`timescale 1ns / 1ps
// Iterative 64-bit integer square root, two radicand bits per cycle, rounded.
// Depends on mgsqr_pkg.
module mgsqr_sqrt
   import mgsqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] n_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            n_ff    <= radicand;
            res_ff  <= '0;
            bit_ff  <= 64'h4000000000000000;
         end else if (busy_ff) begin
            if (n_ff >= trial) begin
               n_ff   <= n_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[32:0] + {32'd0, (n_ff > res_ff)};

endmodule

### design/mgsqr_div.sv
`timescale 1ns / 1ps
// Restoring divider, 48-bit numerator by 31-bit divisor, one bit per cycle.
// Depends on mgsqr_pkg.
module mgsqr_div
   import mgsqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [47:0] numer,
   input  logic [30:0] denom,
   output logic        done,
   output logic [47:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [47:0] num_ff;
   logic [31:0] rem_ff;
   logic [30:0] den_ff;
   logic [31:0] rem_sh;

   assign rem_sh = {rem_ff[30:0], num_ff[47]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
         end else if (busy_ff) begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sh - {1'b0, den_ff};
               num_ff <= {num_ff[46:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               num_ff <= {num_ff[46:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

### design/mgsqr_engine.sv
`timescale 1ns / 1ps
// Factorization sequencer: dot, update and norm passes over the matrix RAM,
// then root and divide. Depends on mgsqr_pkg, mgsqr_sqrt, mgsqr_div.
module mgsqr_engine
   import mgsqr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [CNT_W-1:0]  rows_used,
   input  logic [CNT_W-1:0]  cols_used,
   input  logic [DATA_W-1:0] rdata_a,
   input  logic [DATA_W-1:0] rdata_b,
   output mem_req_type       mem,
   output eng_status_type    stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_DOT, S_UPD, S_NORM, S_DRAIN, S_RIJ, S_SQRT, S_SQRT_WAIT,
      S_DIAG, S_ZERO, S_DIV_RD, S_DIV_LD, S_DIV_WAIT, S_NEXT, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_DOT, MODE_UPD, MODE_NORM
   } mode_type;

   state_type         state_ff;
   mode_type          mode_ff;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff, k1_ff, k2_ff;
   logic              v1_ff, v2_ff;
   logic signed [63:0] prod_ff;
   logic [DATA_W-1:0] b2_ff;
   logic [63:0]       acc_ff;
   logic [DATA_W-1:0] rij_ff;
   logic [DATA_W-1:0] diag_ff;
   logic              sign_ff;
   logic              zero_ff, sat_ff;

   logic              issue, k_last;
   logic signed [31:0] opx, opy;
   logic signed [63:0] prod;
   sat64_type         acc_add;
   sat32_type         upd_sat, rij_sat, diag_sat, q_sat;
   logic [31:0]       mag;
   logic [47:0]       numer;
   logic [47:0]       quot;
   logic [32:0]       root;
   logic              sqrt_done, div_done;
   logic [63:0]       qv;

   assign issue  = (state_ff == S_DOT) || (state_ff == S_UPD) || (state_ff == S_NORM);
   assign k_last = ({1'b0, k_ff} == rows_used - 5'd1);

   assign opx  = (mode_ff == MODE_NORM) ? rdata_b : rdata_a;
   assign opy  = (mode_ff == MODE_UPD) ? rij_ff : rdata_b;
   assign prod = 64'(opx) * 64'(opy);

   assign acc_add = sat_add64(acc_ff, prod_ff);
   assign upd_sat = sat32(64'($signed(b2_ff)) - round16(prod_ff));
   assign rij_sat = sat32(round16(acc_ff));
   assign diag_sat.hit = (root > 33'h07FFFFFFF);
   assign diag_sat.val = diag_sat.hit ? 32'h7FFFFFFF : root[31:0];

   assign mag   = rdata_b[31] ? (~rdata_b + 32'd1) : rdata_b;
   assign numer = {mag, 16'd0} + {18'd0, diag_ff[30:1]};
   assign qv    = sign_ff ? (64'd0 - {16'd0, quot}) : {16'd0, quot};
   assign q_sat = sat32(qv);

   mgsqr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (state_ff == S_SQRT),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   mgsqr_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (state_ff == S_DIV_LD),
      .numer (numer),
      .denom (diag_ff[30:0]),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      mem.addr_a  = {k_ff, (mode_ff == MODE_NORM) ? j_ff : i_ff};
      mem.addr_b  = {k_ff, j_ff};
      mem.q_we    = 1'b0;
      mem.q_waddr = {k_ff, j_ff};
      mem.q_wdata = '0;
      mem.r_we    = 1'b0;
      mem.r_waddr = {i_ff, j_ff};
      mem.r_wdata = rij_sat.val;
      if (v2_ff && mode_ff == MODE_UPD) begin
         mem.q_we    = 1'b1;
         mem.q_waddr = {k2_ff, j_ff};
         mem.q_wdata = upd_sat.val;
      end else if (state_ff == S_ZERO) begin
         mem.q_we = 1'b1;
      end else if (state_ff == S_DIV_WAIT && div_done) begin
         mem.q_we    = 1'b1;
         mem.q_wdata = q_sat.val;
      end
      if (state_ff == S_RIJ) begin
         mem.r_we = 1'b1;
      end else if (state_ff == S_DIAG) begin
         mem.r_we    = 1'b1;
         mem.r_waddr = {j_ff, j_ff};
         mem.r_wdata = diag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         zero_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         v1_ff   <= issue;
         k1_ff   <= k_ff;
         v2_ff   <= v1_ff;
         k2_ff   <= k1_ff;
         prod_ff <= prod;
         b2_ff   <= rdata_b;
         if (v2_ff) begin
            if (mode_ff == MODE_UPD) begin
               sat_ff <= sat_ff | upd_sat.hit;
            end else begin
               acc_ff <= acc_add.val;
               sat_ff <= sat_ff | acc_add.hit;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (go) begin
                  zero_ff  <= 1'b0;
                  sat_ff   <= 1'b0;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  acc_ff   <= '0;
                  mode_ff  <= MODE_NORM;
                  state_ff <= S_NORM;
               end
            end
            S_DOT, S_UPD, S_NORM: begin
               if (k_last) begin
                  k_ff     <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            S_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  unique case (mode_ff)
                     MODE_DOT: state_ff <= S_RIJ;
                     MODE_UPD: begin
                        acc_ff <= '0;
                        if (i_ff + 4'd1 < j_ff) begin
                           i_ff     <= i_ff + 4'd1;
                           mode_ff  <= MODE_DOT;
                           state_ff <= S_DOT;
                        end else begin
                           mode_ff  <= MODE_NORM;
                           state_ff <= S_NORM;
                        end
                     end
                     default: state_ff <= S_SQRT;
                  endcase
               end
            end
            S_RIJ: begin
               rij_ff   <= rij_sat.val;
               sat_ff   <= sat_ff | rij_sat.hit;
               mode_ff  <= MODE_UPD;
               state_ff <= S_UPD;
            end
            S_SQRT: state_ff <= S_SQRT_WAIT;
            S_SQRT_WAIT: begin
               if (sqrt_done) begin
                  diag_ff  <= diag_sat.val;
                  sat_ff   <= sat_ff | diag_sat.hit;
                  state_ff <= S_DIAG;
               end
            end
            S_DIAG: begin
               k_ff <= '0;
               if (diag_ff == '0) begin
                  zero_ff  <= 1'b1;
                  state_ff <= S_ZERO;
               end else begin
                  state_ff <= S_DIV_RD;
               end
            end
            S_ZERO: begin
               if (k_last) begin
                  state_ff <= S_NEXT;
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            S_DIV_RD: state_ff <= S_DIV_LD;
            S_DIV_LD: begin
               sign_ff  <= rdata_b[31];
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  sat_ff <= sat_ff | q_sat.hit;
                  if (k_last) begin
                     state_ff <= S_NEXT;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= S_DIV_RD;
                  end
               end
            end
            S_NEXT: begin
               k_ff <= '0;
               if ({1'b0, j_ff} == cols_used - 5'd1) begin
                  state_ff <= S_DONE;
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  i_ff     <= '0;
                  acc_ff   <= '0;
                  mode_ff  <= MODE_DOT;
                  state_ff <= S_DOT;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign stat.busy      = (state_ff != S_IDLE);
   assign stat.done      = (state_ff == S_DONE);
   assign stat.zero_norm = zero_ff;
   assign stat.saturated = sat_ff;

endmodule

### design/mgs_qr_factorization_top.sv
`timescale 1ns / 1ps
// MGS QR unit top: element write/read words go one per cycle when idle, result
// strobe follows via the s1 and response registers; the receiver cannot stall. A
// start word holds busy through the projections, column norms and roots, and Q
// element divides (or zero-column clears); its result word is registered from
// done. Synchronous active-high reset clears flags and sizes (16 x 16); matrix
// contents undefined. Depends on mgsqr_pkg, mgsqr_ram, mgsqr_engine.
module mgs_qr_factorization_top
   import mgsqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic signed [31:0] req_write_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_saturated,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [CNT_W-1:0]  rows_ff, cols_ff, cfg_val;
   logic              accept, bad, below;
   action_type        act;
   logic [ADDR_W-1:0] host_addr;
   logic              host_we;
   mem_req_type       mem;
   eng_status_type    stat;
   logic [DATA_W-1:0] qa_rdata, qb_rdata, r_rdata;
   logic [ADDR_W-1:0] qa_raddr, qb_raddr, q_waddr;
   logic              q_we;
   logic [DATA_W-1:0] q_wdata;

   logic              s1_valid_ff, s1_bad_ff, s1_blank_ff;
   action_type        s1_act_ff;
   logic              rsp_valid_ff, rsp_sat_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;

   assign act       = action_type'(req_action);
   assign accept    = start && !stat.busy;
   assign host_addr = {req_row, req_col};
   assign bad       = (act == ACT_READ_R) ?
                      ({1'b0, req_row} >= cols_ff || {1'b0, req_col} >= cols_ff) :
                      ({1'b0, req_row} >= rows_ff || {1'b0, req_col} >= cols_ff);
   assign below     = (act == ACT_READ_R) && (req_row > req_col);
   assign host_we   = accept && (act == ACT_WRITE) && !bad;

   assign qa_raddr = stat.busy ? mem.addr_a : host_addr;
   assign qb_raddr = mem.addr_b;
   assign q_we     = stat.busy ? mem.q_we : host_we;
   assign q_waddr  = stat.busy ? mem.q_waddr : host_addr;
   assign q_wdata  = stat.busy ? mem.q_wdata : req_write_value;

   mgsqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_q_ram_a (
      .clock (clock), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
      .raddr (qa_raddr), .rdata (qa_rdata)
   );

   mgsqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_q_ram_b (
      .clock (clock), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
      .raddr (qb_raddr), .rdata (qb_rdata)
   );

   mgsqr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_r_ram (
      .clock (clock), .we (mem.r_we), .waddr (mem.r_waddr), .wdata (mem.r_wdata),
      .raddr (host_addr), .rdata (r_rdata)
   );

   mgsqr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .go        (accept && act == ACT_START),
      .rows_used (rows_ff),
      .cols_used (cols_ff),
      .rdata_a   (qa_rdata),
      .rdata_b   (qb_rdata),
      .mem       (mem),
      .stat      (stat)
   );

   // register writes clamp to 1..max
   always_comb begin
      cfg_val = pwdata[4:0];
      if (cfg_val == '0) begin
         cfg_val = 5'd1;
      end else if (cfg_val > 5'(MAX_ROWS)) begin
         cfg_val = 5'(MAX_ROWS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= 5'(MAX_ROWS);
         cols_ff      <= 5'(MAX_COLS);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr[2]) begin
               cols_ff <= cfg_val;
            end else begin
               rows_ff <= cfg_val;
            end
         end
         s1_valid_ff <= accept && (act != ACT_START);
         s1_act_ff   <= act;
         s1_bad_ff   <= bad;
         s1_blank_ff <= bad || below || (act == ACT_WRITE);
         rsp_valid_ff <= s1_valid_ff || stat.done;
         rsp_sat_ff   <= stat.saturated;
         if (s1_valid_ff && s1_bad_ff) begin
            rsp_status_ff <= ST_BAD_INDEX;
         end else if (stat.zero_norm) begin
            rsp_status_ff <= ST_ZERO_NORM;
         end else begin
            rsp_status_ff <= ST_OK;
         end
         if (!s1_valid_ff || s1_blank_ff) begin
            rsp_value_ff <= '0;
         end else if (s1_act_ff == ACT_READ_R) begin
            rsp_value_ff <= r_rdata;
         end else begin
            rsp_value_ff <= qa_rdata;
         end
      end
   end

   assign busy           = stat.busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign prdata         = paddr[2] ? {27'd0, cols_ff} : {27'd0, rows_ff};
   assign pready         = 1'b1;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && act == ACT_START) |=> busy)
      else $error("start word did not raise busy");

   a_no_eng_write_idle: assert property (@(posedge clock) disable iff (reset)
      !stat.busy |-> (!mem.q_we && !mem.r_we))
      else $error("engine wrote memory while idle");

   a_flags_idle: assert property (@(posedge clock) disable iff (reset)
      (!stat.busy && !accept) |=> ($stable(stat.zero_norm) && $stable(stat.saturated)))
      else $error("flags changed while idle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_ZERO_NORM ||
                     rsp_status == ST_BAD_INDEX))
      else $error("illegal status code");

endmodule

### tb/mgs_qr_factorization_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MGS QR unit: element writes, factorization, Q/R reads,
// size registers over the APB-style port, with a built-in fixed-point predictor.
// Depends on mgsqr_pkg and mgs_qr_factorization_top.
module mgs_qr_factorization_top_test;
   import mgsqr_pkg::*;

   localparam logic [2:0] ADDR_ROWS = 3'd0;
   localparam logic [2:0] ADDR_COLS = 3'd4;

   typedef struct {
      action_type        act;
      logic [3:0]        row;
      logic [3:0]        col;
      logic signed [31:0] wv;
   } word_type;

   typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               sat;
   } reply_type;

   logic        clock, reset, start, busy;
   logic [1:0]  req_action;
   logic [3:0]  req_row, req_col;
   logic signed [31:0] req_write_value;
   logic        rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic [1:0]  rsp_status;
   logic        rsp_saturated;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   mgs_qr_factorization_top dut (.*);

   word_type  pending_words[$];
   reply_type expected_replies[$];
   int     errors = 0;
   int     idle_pct = 7;

   // predictor state
   logic signed [31:0] q_mem[256];
   logic signed [31:0] r_mem[256];
   bit     zero_norm, sat_flag;
   int     m_rows = 16, n_cols = 16;

   // generator-side bookkeeping of written entries
   bit     q_done[256];
   bit     r_done[256];
   int     gen_m = 16, gen_n = 16;
   int     word_count = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint rnd16(longint x);
      return (x >>> 16) + longint'(x[15]);
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sh7FFFFFFF) begin
         sat_flag = 1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sh80000000) begin
         sat_flag = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic longint add_clip64(longint a, longint b);
      longint s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
         sat_flag = 1;
         return 64'sh7FFFFFFFFFFFFFFF;
      end
      if (a[63] && b[63] && !s[63]) begin
         sat_flag = 1;
         return 64'sh8000000000000000;
      end
      return s;
   endfunction

   function automatic longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void factorize();
      longint acc, a, d;
      longint unsigned s, root, mag, q, dv;
      logic signed [31:0] rij, diag;
      zero_norm = 0;
      sat_flag = 0;
      for (int j = 0; j < n_cols; j++) begin
         for (int i = 0; i < j; i++) begin
            acc = 0;
            for (int k = 0; k < m_rows; k++)
               acc = add_clip64(acc, longint'(q_mem[k*16+i]) * longint'(q_mem[k*16+j]));
            rij = clip32(rnd16(acc));
            r_mem[i*16+j] = rij;
            for (int k = 0; k < m_rows; k++) begin
               d = rnd16(longint'(q_mem[k*16+i]) * longint'(rij));
               q_mem[k*16+j] = clip32(longint'(q_mem[k*16+j]) - d);
            end
         end
         acc = 0;
         for (int k = 0; k < m_rows; k++) begin
            a = q_mem[k*16+j];
            acc = add_clip64(acc, a * a);
         end
         s = acc;
         root = sqrt_floor(s);
         if (s - root * root > root) root++;
         diag = clip32(longint'(root));
         r_mem[j*16+j] = diag;
         if (diag == 0) begin
            zero_norm = 1;
            for (int k = 0; k < m_rows; k++) q_mem[k*16+j] = 0;
         end else begin
            dv = longint'(diag);
            for (int k = 0; k < m_rows; k++) begin
               a = q_mem[k*16+j];
               mag = a < 0 ? -a : a;
               q = ((mag << 16) + dv / 2) / dv;
               q_mem[k*16+j] = clip32(a < 0 ? -longint'(q) : longint'(q));
            end
         end
      end
   endfunction

   function automatic reply_type predict_reply(action_type act, int r, int c,
                                               logic signed [31:0] wv);
      reply_type e;
      bit bad;
      e.value = 0;
      bad = 0;
      case (act)
         ACT_START: factorize();
         ACT_READ_R: begin
            if (r >= n_cols || c >= n_cols) bad = 1;
            else if (r <= c) e.value = r_mem[r*16+c];
         end
         default: begin
            if (r >= m_rows || c >= n_cols) bad = 1;
            else if (act == ACT_WRITE) q_mem[r*16+c] = wv;
            else e.value = q_mem[r*16+c];
         end
      endcase
      e.status = bad ? ST_BAD_INDEX : (zero_norm ? ST_ZERO_NORM : ST_OK);
      e.sat = sat_flag;
      return e;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_action <= ACT_WRITE;
         req_row <= 0;
         req_col <= 0;
         req_write_value <= 0;
      end else if (!(start && busy)) begin
         if (start) pending_words.pop_front();
         if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1;
            req_action <= pending_words[0].act;
            req_row <= pending_words[0].row;
            req_col <= pending_words[0].col;
            req_write_value <= pending_words[0].wv;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report("unexpected word", rsp_read_value, 0);
            end else begin
               e = expected_replies.pop_front();
               if (rsp_read_value !== e.value) report("read_value", rsp_read_value, e.value);
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
               if (rsp_saturated !== e.sat) report("saturated", rsp_saturated, e.sat);
            end
         end
         if (start && !busy)
            expected_replies.push_back(predict_reply(action_type'(req_action), req_row,
                                                     req_col, req_write_value));
      end
   end

   task automatic push_word(action_type act, int r, int c, logic signed [31:0] wv);
      word_type w;
      w.act = act;
      w.row = 4'(r);
      w.col = 4'(c);
      w.wv = wv;
      pending_words.push_back(w);
      word_count++;
      if (act == ACT_WRITE && r < gen_m && c < gen_n) q_done[r*16+c] = 1;
      if (act == ACT_START) begin
         for (int j = 0; j < gen_n; j++) begin
            for (int k = 0; k < gen_m; k++) q_done[k*16+j] = 1;
            for (int i = 0; i <= j; i++) r_done[i*16+j] = 1;
         end
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_words.size() != 0 || start || expected_replies.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   function automatic int clamp_size(logic [31:0] raw);
      int v;
      v = raw[4:0];
      if (v == 0) v = 1;
      return v > 16 ? 16 : v;
   endfunction

   task automatic set_size(logic [31:0] rows_raw, logic [31:0] cols_raw);
      drain();
      csr_write(ADDR_ROWS, rows_raw);
      csr_write(ADDR_COLS, cols_raw);
      m_rows = clamp_size(rows_raw);
      n_cols = clamp_size(cols_raw);
      gen_m = m_rows;
      gen_n = n_cols;
   endtask

   function automatic logic [31:0] encode_size(int v);
      logic [31:0] raw;
      raw = $urandom & ~32'h1F;
      if (v == 1 && $urandom_range(2) == 0) return raw;
      if (v == 16 && $urandom_range(1) == 0) return raw | $urandom_range(31, 17);
      return raw | v;
   endfunction

   function automatic logic signed [31:0] rand_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $signed($urandom_range(32'h000FFFFF)) - 32'sh00080000;
      if (pick < 78) return $urandom;
      if (pick < 88) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      return 0;
   endfunction

   task automatic push_read();
      action_type act;
      int r, c;
      for (int t = 0; t < 20; t++) begin
         act = $urandom_range(1) ? ACT_READ_Q : ACT_READ_R;
         r = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(gen_m - 1);
         c = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(gen_n - 1);
         if (act == ACT_READ_Q && (r >= gen_m || c >= gen_n || q_done[r*16+c])) begin
            push_word(act, r, c, $urandom);
            return;
         end
         if (act == ACT_READ_R && (r >= gen_n || c >= gen_n || r > c || r_done[r*16+c])) begin
            push_word(act, r, c, $urandom);
            return;
         end
      end
      push_word(ACT_READ_R, 15, 0, 0);
   endtask

   task automatic run_block(int m, int n);
      int copy_col;
      set_size(encode_size(m), encode_size(n));
      copy_col = (n > 1 && $urandom_range(4) == 0) ? $urandom_range(n - 1) : -1;
      for (int j = 0; j < n; j++) begin
         for (int i = 0; i < m; i++) begin
            if (copy_col == j && $urandom_range(1)) push_word(ACT_WRITE, i, j, 0);
            else push_word(ACT_WRITE, i, j, rand_value());
            if ($urandom_range(19) == 0) push_word(ACT_WRITE, $urandom_range(15),
                                                     $urandom_range(15), $urandom);
         end
      end
      if ($urandom_range(3) == 0) push_read();
      push_word(ACT_START, $urandom_range(15), $urandom_range(15), $urandom);
      repeat ($urandom_range(m * n + 4, 2)) push_read();
      if ($urandom_range(5) == 0) begin
         push_word(ACT_START, 0, 0, 0);
         push_read();
      end
   endtask

   task automatic random_phase(int goal);
      int m, n;
      int big;
      big = 0;
      while (word_count < goal) begin
         m = $urandom_range(4, 1);
         n = $urandom_range(4, 1);
         case ($urandom_range(19))
            0: m = 16;
            1: n = 16;
            2: begin
               if (big == 0) begin
                  m = 16;
                  n = 16;
                  big = 1;
               end
            end
            default: ;
         endcase
         if (m == 16 && n > 4 && !(n == 16 && big == 1)) n = $urandom_range(3, 1);
         if (n == 16 && m > 2 && m != 16) m = 2;
         run_block(m, n);
      end
   endtask

   initial begin
      reset = 1;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // extremes, saturating root, zero column, bad index, below diagonal
      set_size(2, 2);
      push_word(ACT_WRITE, 0, 0, 32'sh7FFFFFFF);
      push_word(ACT_WRITE, 1, 0, 32'sh80000000);
      push_word(ACT_WRITE, 0, 1, 0);
      push_word(ACT_WRITE, 1, 1, 0);
      push_word(ACT_READ_Q, 1, 0, 0);
      push_word(ACT_START, 0, 0, 0);
      for (int r = 0; r < 2; r++)
         for (int c = 0; c < 2; c++) begin
            push_word(ACT_READ_Q, r, c, 0);
            push_word(ACT_READ_R, r, c, 0);
         end
      push_word(ACT_READ_R, 2, 0, 0);
      push_word(ACT_WRITE, 15, 15, 32'shFFFFFFFF);
      push_word(ACT_READ_Q, 0, 15, 0);
      set_size(0, 1);
      push_word(ACT_WRITE, 0, 0, 32'sh00010000);
      push_word(ACT_START, 15, 15, 0);
      push_word(ACT_READ_Q, 0, 0, 0);
      push_word(ACT_READ_R, 0, 0, 0);
      set_size(16, 1);
      for (int i = 0; i < 16; i++) push_word(ACT_WRITE, i, 0, 32'sh80000000);
      push_word(ACT_START, 0, 0, 0);
      push_word(ACT_READ_R, 0, 0, 0);
      word_count = 0;

      idle_pct = 7;
      random_phase(630);
      drain();
      idle_pct = 81;
      random_phase(1260);
      drain();
      idle_pct = 0;
      random_phase(1900);
      drain();
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
